/* src/mer_pkg.sv */
// Shared types and constants for the midpoint ellipse rasterizer.
package mer_pkg;

  localparam int COORD_BITS_DEF = 11;

  // Operand pair fed to the shared multiplier
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_RX2_RY,
    MUL_TX_TX,
    MUL_YM_YM,
    MUL_RY2_TMP,
    MUL_RX2_TMP,
    MUL_RX2_RY2
  } mul_op_t;

  // What to do with the registered product
  typedef enum logic [2:0] {
    TAKE_NONE,
    TAKE_RX2,
    TAKE_RY2,
    TAKE_SY,
    TAKE_TMP,
    TAKE_ACC,
    TAKE_ADD4,
    TAKE_SUB4
  } take_op_t;

  // Load, advance and decision update steps
  typedef enum logic [2:0] {
    SEQ_NONE,
    SEQ_START,
    SEQ_ADVANCE,
    SEQ_ACC_SX,
    SEQ_ACC_SY,
    SEQ_DEC_ADD,
    SEQ_DEC_LOAD
  } seq_op_t;

  typedef struct packed {
    mul_op_t  mul_op;
    take_op_t take_op;
    seq_op_t  seq_op;
    logic     region_one;
    logic     emit_load;
    logic     shape_done;
  } dp_cmd_t;

  typedef struct packed {
    logic r1_end;
    logic y_neg;
    logic y_zero;
  } dp_status_t;

endpackage

/* src/mer_if.sv */
// Valid/ready channel interfaces for the rasterizer input and pixel output.
interface mer_in_if #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] corner_ax;
  logic [COORD_BITS-1:0] corner_ay;
  logic [COORD_BITS-1:0] corner_bx;
  logic [COORD_BITS-1:0] corner_by;

  modport source (
    output valid, action, corner_ax, corner_ay, corner_bx, corner_by,
    input  ready
  );
  modport sink (
    input  valid, action, corner_ax, corner_ay, corner_bx, corner_by,
    output ready
  );
endinterface

interface mer_out_if #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  step_last;
  logic                  shape_done;

  modport source (
    output valid, pixel_x, pixel_y, step_last, shape_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, step_last, shape_done,
    output ready
  );
endinterface

/* src/mer_ctrl.sv */
// Sequencer for the ellipse rasterizer: start setup, point advance, region change.
module mer_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_ready,
  input  logic                emit_busy,
  input  mer_pkg::dp_status_t status,
  output mer_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    REGION_IDLE = 2'd0,
    REGION_ONE  = 2'd1,
    REGION_TWO  = 2'd2
  } region_t;

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_ST1  = 17'h00002,
    S_ST2  = 17'h00004,
    S_ST3  = 17'h00008,
    S_ST4  = 17'h00010,
    S_ST5  = 17'h00020,
    S_U2   = 17'h00040,
    S_U3   = 17'h00080,
    S_U4   = 17'h00100,
    S_RA1  = 17'h00200,
    S_RA2  = 17'h00400,
    S_RA3  = 17'h00800,
    S_RA4  = 17'h01000,
    S_RA5  = 17'h02000,
    S_RA6  = 17'h04000,
    S_RA7  = 17'h08000,
    S_SETL = 17'h10000
  } state_t;

  state_t  state_r, state_nxt;
  region_t region_r, region_nxt;
  logic    xfer;

  assign in_ready = (state_r == S_IDLE) && !emit_busy;
  assign xfer     = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    region_nxt     = region_r;
    cmd            = '0;
    cmd.mul_op     = mer_pkg::MUL_NONE;
    cmd.take_op    = mer_pkg::TAKE_NONE;
    cmd.seq_op     = mer_pkg::SEQ_NONE;
    cmd.region_one = (region_r == REGION_ONE);
    case (state_r)
      S_IDLE: begin
        if (xfer) begin
          if (!in_action) begin
            cmd.seq_op = mer_pkg::SEQ_START;
            state_nxt  = S_ST1;
          end else if (region_r != REGION_IDLE) begin
            cmd.seq_op     = mer_pkg::SEQ_ADVANCE;
            cmd.emit_load  = 1'b1;
            // region two with y at zero steps below the axis: last point
            cmd.shape_done = (region_r == REGION_TWO) && status.y_zero;
            state_nxt      = S_U2;
          end
        end
      end
      S_ST1: begin
        cmd.mul_op = mer_pkg::MUL_RX_RX;
        state_nxt  = S_ST2;
      end
      S_ST2: begin
        cmd.mul_op  = mer_pkg::MUL_RY_RY;
        cmd.take_op = mer_pkg::TAKE_RX2;
        state_nxt   = S_ST3;
      end
      S_ST3: begin
        cmd.mul_op  = mer_pkg::MUL_RX2_RY;
        cmd.take_op = mer_pkg::TAKE_RY2;
        state_nxt   = S_ST4;
      end
      S_ST4: begin
        cmd.take_op = mer_pkg::TAKE_SY;
        state_nxt   = S_ST5;
      end
      S_ST5: begin
        cmd.seq_op = mer_pkg::SEQ_DEC_LOAD;
        region_nxt = REGION_ONE;
        state_nxt  = S_SETL;
      end
      S_U2: begin
        cmd.seq_op = mer_pkg::SEQ_ACC_SX;
        state_nxt  = S_U3;
      end
      S_U3: begin
        cmd.seq_op = mer_pkg::SEQ_ACC_SY;
        state_nxt  = S_U4;
      end
      S_U4: begin
        cmd.seq_op = mer_pkg::SEQ_DEC_ADD;
        state_nxt  = S_SETL;
      end
      S_RA1: begin
        cmd.mul_op = mer_pkg::MUL_TX_TX;
        state_nxt  = S_RA2;
      end
      S_RA2: begin
        cmd.mul_op  = mer_pkg::MUL_YM_YM;
        cmd.take_op = mer_pkg::TAKE_TMP;
        state_nxt   = S_RA3;
      end
      S_RA3: begin
        cmd.mul_op  = mer_pkg::MUL_RY2_TMP;
        cmd.take_op = mer_pkg::TAKE_TMP;
        state_nxt   = S_RA4;
      end
      S_RA4: begin
        cmd.mul_op  = mer_pkg::MUL_RX2_TMP;
        cmd.take_op = mer_pkg::TAKE_ACC;
        state_nxt   = S_RA5;
      end
      S_RA5: begin
        cmd.mul_op  = mer_pkg::MUL_RX2_RY2;
        cmd.take_op = mer_pkg::TAKE_ADD4;
        state_nxt   = S_RA6;
      end
      S_RA6: begin
        cmd.take_op = mer_pkg::TAKE_SUB4;
        state_nxt   = S_RA7;
      end
      S_RA7: begin
        cmd.seq_op = mer_pkg::SEQ_DEC_LOAD;
        region_nxt = REGION_TWO;
        state_nxt  = S_SETL;
      end
      S_SETL: begin
        if ((region_r == REGION_ONE) && status.r1_end) begin
          state_nxt = S_RA1;
        end else begin
          if ((region_r == REGION_TWO) && status.y_neg) begin
            region_nxt = REGION_IDLE;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      region_r <= REGION_IDLE;
    end else begin
      state_r  <= state_nxt;
      region_r <= region_nxt;
    end
  end

`ifndef SYNTHESIS
  a_step_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && in_action && (region_r != REGION_IDLE)) |=> emit_busy)
    else $error("accepted step did not start pixel output");

  a_no_skip_region: assert property (@(posedge clk) disable iff (!rst_n)
    (region_r == REGION_IDLE) |=> (region_r != REGION_TWO))
    else $error("region two entered without region one");

  a_region_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == S_ST5 || state_r == S_RA7 || state_r == S_SETL) |=> $stable(region_r))
    else $error("region changed outside a settle point");

  a_ra_from_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RA1) |-> (region_r == REGION_ONE))
    else $error("region two setup started outside region one");
`endif

endmodule

/* src/mer_datapath.sv */
// Ellipse datapath: geometry registers, shared multiplier, decision terms.
module mer_datapath #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  mer_pkg::dp_cmd_t             cmd,
  input  logic [COORD_BITS-1:0]        corner_ax,
  input  logic [COORD_BITS-1:0]        corner_ay,
  input  logic [COORD_BITS-1:0]        corner_bx,
  input  logic [COORD_BITS-1:0]        corner_by,
  output mer_pkg::dp_status_t          status,
  output logic [COORD_BITS-1:0]        centre_x,
  output logic [COORD_BITS-1:0]        centre_y,
  output logic signed [COORD_BITS:0]   point_x,
  output logic signed [COORD_BITS:0]   point_y
);

  localparam int CW  = COORD_BITS;
  localparam int RW  = CW - 1;
  localparam int PW  = CW + 1;
  localparam int SW  = 2 * RW;
  localparam int MOW = 2 * CW + 2;
  localparam int DW  = 4 * CW + 4;
  localparam logic signed [DW-1:0] DEC_BIAS = DW'(3);

  logic [RW-1:0]           rx_r, ry_r;
  logic [CW-1:0]           cx_r, cy_r;
  logic signed [PW-1:0]    px_r, py_r;
  logic [SW-1:0]           rx2_r, ry2_r;
  logic [MOW-1:0]          tmp_r;
  logic [2*MOW-1:0]        prod_r;
  logic signed [DW-1:0]    acc_r, sx_r, sy_r, dec_r;
  logic                    mvx_r, mvy_r;

  logic                    ax_lt, ay_lt;
  logic [CW-1:0]           wx, wy;
  logic [RW-1:0]           rx_new, ry_new;
  logic [CW-1:0]           cx_new, cy_new;
  logic [MOW-1:0]          op_a, op_b;
  logic signed [PW-1:0]    ym;
  logic [PW-1:0]           ym_abs;
  logic [CW:0]             tx;
  logic signed [DW-1:0]    prod_s, rx2_w, ry2_w, acc_bias, dec_trunc;
  logic                    d_neg, d_pos, mx, my;

  // start geometry: radius is half the box, centre one radius in from corner a
  assign ax_lt  = corner_ax < corner_bx;
  assign ay_lt  = corner_ay < corner_by;
  assign wx     = ax_lt ? (corner_bx - corner_ax) : (corner_ax - corner_bx);
  assign wy     = ay_lt ? (corner_by - corner_ay) : (corner_ay - corner_by);
  assign rx_new = wx[CW-1:1];
  assign ry_new = wy[CW-1:1];
  assign cx_new = ax_lt ? (corner_ax + {1'b0, rx_new}) : (corner_ax - {1'b0, rx_new});
  assign cy_new = ay_lt ? (corner_ay + {1'b0, ry_new}) : (corner_ay - {1'b0, ry_new});

  assign tx     = {px_r[CW-1:0], 1'b1};
  assign ym     = py_r - PW'(1);
  assign ym_abs = ym[PW-1] ? PW'(-ym) : PW'(ym);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_op)
      mer_pkg::MUL_RX_RX: begin
        op_a = MOW'(rx_r);
        op_b = MOW'(rx_r);
      end
      mer_pkg::MUL_RY_RY: begin
        op_a = MOW'(ry_r);
        op_b = MOW'(ry_r);
      end
      mer_pkg::MUL_RX2_RY: begin
        op_a = MOW'(rx2_r);
        op_b = MOW'(ry_r);
      end
      mer_pkg::MUL_TX_TX: begin
        op_a = MOW'(tx);
        op_b = MOW'(tx);
      end
      mer_pkg::MUL_YM_YM: begin
        op_a = MOW'(ym_abs);
        op_b = MOW'(ym_abs);
      end
      mer_pkg::MUL_RY2_TMP: begin
        op_a = MOW'(ry2_r);
        op_b = tmp_r;
      end
      mer_pkg::MUL_RX2_TMP: begin
        op_a = MOW'(rx2_r);
        op_b = tmp_r;
      end
      mer_pkg::MUL_RX2_RY2: begin
        op_a = MOW'(rx2_r);
        op_b = MOW'(ry2_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_s    = signed'(DW'(prod_r));
  assign rx2_w     = signed'(DW'(rx2_r));
  assign ry2_w     = signed'(DW'(ry2_r));
  // quarter-unit value to integer, truncating toward zero
  assign acc_bias  = acc_r + DEC_BIAS;
  assign dec_trunc = acc_r[DW-1] ? (acc_bias >>> 2) : (acc_r >>> 2);

  assign d_neg = dec_r[DW-1];
  assign d_pos = !d_neg && (dec_r != '0);
  assign mx    = cmd.region_one || !d_pos;
  assign my    = !cmd.region_one || !d_neg;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;

    case (cmd.take_op)
      mer_pkg::TAKE_RX2: begin
        rx2_r <= prod_r[SW-1:0];
        acc_r <= prod_s;
      end
      mer_pkg::TAKE_RY2: begin
        ry2_r <= prod_r[SW-1:0];
        acc_r <= acc_r + (prod_s <<< 2);
      end
      mer_pkg::TAKE_SY: begin
        sy_r  <= prod_s <<< 1;
        acc_r <= acc_r - (prod_s <<< 2);
      end
      mer_pkg::TAKE_TMP:  tmp_r <= prod_r[MOW-1:0];
      mer_pkg::TAKE_ACC:  acc_r <= prod_s;
      mer_pkg::TAKE_ADD4: acc_r <= acc_r + (prod_s <<< 2);
      mer_pkg::TAKE_SUB4: acc_r <= acc_r - (prod_s <<< 2);
      default: begin
      end
    endcase

    case (cmd.seq_op)
      mer_pkg::SEQ_START: begin
        rx_r <= rx_new;
        ry_r <= ry_new;
        cx_r <= cx_new;
        cy_r <= cy_new;
        px_r <= '0;
        py_r <= signed'(PW'(ry_new));
        sx_r <= '0;
      end
      mer_pkg::SEQ_ADVANCE: begin
        mvx_r <= mx;
        mvy_r <= my;
        if (mx) begin
          px_r <= px_r + PW'(1);
          sx_r <= sx_r + (ry2_w <<< 1);
        end
        if (my) begin
          py_r <= py_r - PW'(1);
          sy_r <= sy_r - (rx2_w <<< 1);
        end
      end
      mer_pkg::SEQ_ACC_SX: begin
        acc_r <= (mvx_r ? sx_r : '0) + (cmd.region_one ? ry2_w : rx2_w);
      end
      mer_pkg::SEQ_ACC_SY: begin
        acc_r <= acc_r - (mvy_r ? sy_r : '0);
      end
      mer_pkg::SEQ_DEC_ADD:  dec_r <= dec_r + acc_r;
      mer_pkg::SEQ_DEC_LOAD: dec_r <= dec_trunc;
      default: begin
      end
    endcase
  end

  assign status.r1_end = !(sx_r < sy_r);
  assign status.y_neg  = py_r[PW-1];
  assign status.y_zero = (py_r == '0);

  assign centre_x = cx_r;
  assign centre_y = cy_r;
  assign point_x  = px_r;
  assign point_y  = py_r;

endmodule

/* src/mer_emit.sv */
// Pixel output stage: four mirrored pixels of one point, one per transfer.
module mer_emit #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic                        done,
  input  logic [COORD_BITS-1:0]       centre_x,
  input  logic [COORD_BITS-1:0]       centre_y,
  input  logic signed [COORD_BITS:0]  point_x,
  input  logic signed [COORD_BITS:0]  point_y,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [COORD_BITS-1:0]       pixel_x,
  output logic [COORD_BITS-1:0]       pixel_y,
  output logic                        step_last,
  output logic                        shape_done
);

  localparam int CW = COORD_BITS;

  logic          busy_r;
  logic [1:0]    k_r;
  logic [CW-1:0] xm_r, xp_r, ym_r, yp_r;
  logic          done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      k_r    <= '0;
    end else if (busy_r && out_ready) begin
      if (&k_r) begin
        busy_r <= 1'b0;
      end
      k_r <= k_r + 2'd1;
    end
  end

  // coordinates wrap to the pixel width
  always_ff @(posedge clk) begin
    if (load) begin
      xm_r   <= centre_x - point_x[CW-1:0];
      xp_r   <= centre_x + point_x[CW-1:0];
      ym_r   <= centre_y - point_y[CW-1:0];
      yp_r   <= centre_y + point_y[CW-1:0];
      done_r <= done;
    end
  end

  assign busy       = busy_r;
  assign out_valid  = busy_r;
  assign pixel_x    = k_r[1] ? xp_r : xm_r;
  assign pixel_y    = k_r[0] ? yp_r : ym_r;
  assign step_last  = &k_r;
  assign shape_done = done_r;

endmodule

/* src/midpoint_ellipse_rasterizer_core.sv */
// Top level of the midpoint ellipse rasterizer.
//
//  channel | dir | transfer when        | payload
//  in_ch   | in  | valid && ready       | action, corner_ax/ay, corner_bx/by
//  out_ch  | out | valid && ready       | pixel_x, pixel_y, step_last, shape_done
//
// After its transfer a step runs the update and settle states before the next
// item can be taken; its four pixels leave one per cycle while out_ch is ready.
// A start runs three chained squares/products on one shared multiplier, and
// entering region two adds five more multiplies. Reset (rst_n low, synchronous)
// returns the block to no ellipse; steps then produce nothing. A stalled out_ch
// holds the pixel and keeps in_ch.ready low.
module midpoint_ellipse_rasterizer_core #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  mer_in_if.sink     in_ch,
  mer_out_if.source  out_ch
);

  mer_pkg::dp_cmd_t             cmd;
  mer_pkg::dp_status_t          status;
  logic                         emit_busy;
  logic [COORD_BITS-1:0]        centre_x, centre_y;
  logic signed [COORD_BITS:0]   point_x, point_y;

  // Sequencer: owns the region and walks the multiply and update steps.
  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .emit_busy (emit_busy),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: geometry, slope terms and the decision value.
  mer_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .corner_ax (in_ch.corner_ax),
    .corner_ay (in_ch.corner_ay),
    .corner_bx (in_ch.corner_bx),
    .corner_by (in_ch.corner_by),
    .status    (status),
    .centre_x  (centre_x),
    .centre_y  (centre_y),
    .point_x   (point_x),
    .point_y   (point_y)
  );

  // Output stage: capture the point before it advances, then send the four
  // mirrored pixels while the datapath works out the next point.
  mer_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (cmd.emit_load),
    .done       (cmd.shape_done),
    .centre_x   (centre_x),
    .centre_y   (centre_y),
    .point_x    (point_x),
    .point_y    (point_y),
    .busy       (emit_busy),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .pixel_x    (out_ch.pixel_x),
    .pixel_y    (out_ch.pixel_y),
    .step_last  (out_ch.step_last),
    .shape_done (out_ch.shape_done)
  );

endmodule

/* sim/mer_pixel_checker.sv */
// Pixel predictor and scoreboard for the midpoint ellipse rasterizer testbench.
package mer_tb_pkg;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } shape_action_t;

endpackage

module mer_pixel_checker #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mer_in_if    in_mon,
  mer_out_if   out_mon,
  output int   fail_count,
  output int   pixels_owed
);

  typedef enum logic [1:0] {
    TRACE_IDLE,
    TRACE_REGION_ONE,
    TRACE_REGION_TWO
  } trace_region_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  step_last;
    logic                  shape_done;
  } pixel_t;

  pixel_t owed_q[$];

  longint        ctr_x, ctr_y, rad_x, rad_y, rx_sq, ry_sq;
  longint        pt_x, pt_y, grad_x, grad_y, mid_err;
  trace_region_t arc_phase;

  function automatic void clear_trace();
    ctr_x = 0; ctr_y = 0; rad_x = 0; rad_y = 0; rx_sq = 0; ry_sq = 0;
    pt_x = 0; pt_y = 0; grad_x = 0; grad_y = 0; mid_err = 0;
    arc_phase = TRACE_IDLE;
  endfunction

  // Switch to region two once the slopes cross, and stop once y drops below zero.
  function automatic void check_region_end();
    longint tx, ym;
    if (arc_phase == TRACE_REGION_ONE && !(grad_x < grad_y)) begin
      tx = 2 * pt_x + 1;
      ym = pt_y - 1;
      mid_err = (ry_sq * tx * tx + 4 * rx_sq * ym * ym - 4 * rx_sq * ry_sq) / 4;
      arc_phase = TRACE_REGION_TWO;
    end
    if (arc_phase == TRACE_REGION_TWO && pt_y < 0)
      arc_phase = TRACE_IDLE;
  endfunction

  function automatic void load_box(logic [COORD_BITS-1:0] ax, logic [COORD_BITS-1:0] ay,
                                   logic [COORD_BITS-1:0] bx, logic [COORD_BITS-1:0] by);
    longint a_x, a_y, b_x, b_y;
    a_x = longint'(ax); a_y = longint'(ay);
    b_x = longint'(bx); b_y = longint'(by);
    rad_x = ((a_x < b_x) ? b_x - a_x : a_x - b_x) / 2;
    rad_y = ((a_y < b_y) ? b_y - a_y : a_y - b_y) / 2;
    ctr_x = (a_x < b_x) ? a_x + rad_x : a_x - rad_x;
    ctr_y = (a_y < b_y) ? a_y + rad_y : a_y - rad_y;
    rx_sq = rad_x * rad_x;
    ry_sq = rad_y * rad_y;
    pt_x = 0;
    pt_y = rad_y;
    mid_err = (4 * ry_sq - 4 * rx_sq * rad_y + rx_sq) / 4;
    grad_x = 0;
    grad_y = 2 * rx_sq * pt_y;
    arc_phase = TRACE_REGION_ONE;
    check_region_end();
  endfunction

  // Queue the four mirrored pixels of the current point, then move to the next one.
  function automatic void trace_step();
    pixel_t quad[4];
    if (arc_phase == TRACE_IDLE)
      return;
    for (int k = 0; k < 4; k++) begin
      quad[k].x         = COORD_BITS'(k[1] ? ctr_x + pt_x : ctr_x - pt_x);
      quad[k].y         = COORD_BITS'(k[0] ? ctr_y + pt_y : ctr_y - pt_y);
      quad[k].step_last = (k == 3);
    end
    if (arc_phase == TRACE_REGION_ONE) begin
      pt_x++;
      grad_x += 2 * ry_sq;
      if (mid_err < 0) begin
        mid_err += grad_x + ry_sq;
      end else begin
        pt_y--;
        grad_y -= 2 * rx_sq;
        mid_err += grad_x - grad_y + ry_sq;
      end
    end else begin
      pt_y--;
      grad_y -= 2 * rx_sq;
      if (mid_err > 0) begin
        mid_err += rx_sq - grad_y;
      end else begin
        pt_x++;
        grad_x += 2 * ry_sq;
        mid_err += grad_x - grad_y + rx_sq;
      end
    end
    check_region_end();
    for (int k = 0; k < 4; k++) begin
      quad[k].shape_done = (arc_phase == TRACE_IDLE);
      owed_q.push_back(quad[k]);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      clear_trace();
      owed_q.delete();
      fail_count = 0;
    end else begin
      // An output transfer never belongs to an input taken at the same edge.
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          fail_count++;
          $error("pixel: unexpected transfer x=%0d y=%0d", out_mon.pixel_x, out_mon.pixel_y);
        end else begin
          want = owed_q.pop_front();
          check_field("pixel_x", 32'(want.x), 32'(out_mon.pixel_x));
          check_field("pixel_y", 32'(want.y), 32'(out_mon.pixel_y));
          check_field("step_last", 32'(want.step_last), 32'(out_mon.step_last));
          check_field("shape_done", 32'(want.shape_done), 32'(out_mon.shape_done));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == mer_tb_pkg::ACT_START)
          load_box(in_mon.corner_ax, in_mon.corner_ay, in_mon.corner_bx, in_mon.corner_by);
        else
          trace_step();
      end
    end
    pixels_owed <= owed_q.size();
  end

endmodule

/* sim/tb_midpoint_ellipse_rasterizer_core.sv */
// Testbench top: drives shapes and steps into the rasterizer and reports the verdict.
module tb_midpoint_ellipse_rasterizer_core;

  localparam int COORD_BITS    = mer_pkg::COORD_BITS_DEF;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int STIM_ITEMS    = 410;
  localparam int IDLE_PCT      = 34;
  // A start may run its setup multiplies, and those for region two, without any pixel.
  localparam int SETTLE_CYCLES = 32;
  // Transfer count window in which neither side idles.
  localparam int STEADY_FROM   = 200;
  localparam int STEADY_TO     = 290;

  logic clk;
  logic rst_n;
  logic steady;
  int   sent;
  int   fail_count;
  int   pixels_owed;

  mer_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
  mer_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

  midpoint_ellipse_rasterizer_core #(.COORD_BITS(COORD_BITS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicts every pixel from the accepted inputs and scores the output channel.
  mer_pixel_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .pixels_owed (pixels_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the pixel sink at random, except inside the steady window.
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Present one item, idling first at random, and hold it until the transfer.
  task automatic send_item(mer_tb_pkg::shape_action_t act,
                           logic [COORD_BITS-1:0] ax, logic [COORD_BITS-1:0] ay,
                           logic [COORD_BITS-1:0] bx, logic [COORD_BITS-1:0] by);
    logic calm;
    calm = (sent >= STEADY_FROM) && (sent < STEADY_TO);
    steady <= calm;
    if (!calm)
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.corner_ax <= ax;
    in_ch.corner_ay <= ay;
    in_ch.corner_bx <= bx;
    in_ch.corner_by <= by;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic start_box(int ax, int ay, int bx, int by);
    send_item(mer_tb_pkg::ACT_START, COORD_BITS'(ax), COORD_BITS'(ay),
              COORD_BITS'(bx), COORD_BITS'(by));
  endtask

  // Corner fields are don't-care on a step; fill them with noise anyway.
  task automatic step_item();
    send_item(mer_tb_pkg::ACT_STEP,
              COORD_BITS'($urandom_range(0, COORD_MAX)), COORD_BITS'($urandom_range(0, COORD_MAX)),
              COORD_BITS'($urandom_range(0, COORD_MAX)), COORD_BITS'($urandom_range(0, COORD_MAX)));
  endtask

  // Hold off the sender until every predicted pixel has been transferred.
  task automatic wait_for_pixels();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pixels_owed != 0) @(posedge clk);
  endtask

  // Place the second corner w away from a, in a random direction that stays in range.
  function automatic int far_corner(int a, int w);
    if (a + w > COORD_MAX)
      return a - w;
    if (a >= w && $urandom_range(0, 1) == 1)
      return a - w;
    return a + w;
  endfunction

  // One well-formed shape: start, then enough steps to finish it, sometimes cut short.
  task automatic random_shape();
    int wx, wy, ax, ay, n_steps;
    wx = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 160) : $urandom_range(0, 24);
    wy = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 160) : $urandom_range(0, 24);
    ax = $urandom_range(0, COORD_MAX);
    ay = $urandom_range(0, COORD_MAX);
    // Every point moves x or y by one, so this many steps always reach the end.
    n_steps = wx / 2 + wy / 2 + 2 + $urandom_range(0, 2);
    if ($urandom_range(0, 7) == 0)
      n_steps = $urandom_range(0, n_steps);
    start_box(ax, ay, far_corner(ax, wx), far_corner(ay, wy));
    repeat (n_steps) step_item();
  endtask

  initial begin
    int base;
    int pick;
    rst_n           <= 1'b0;
    steady          <= 1'b0;
    sent             = 0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= mer_tb_pkg::ACT_STEP;
    in_ch.corner_ax <= '0;
    in_ch.corner_ay <= '0;
    in_ch.corner_bx <= '0;
    in_ch.corner_by <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Step with no ellipse loaded: drop silently.
    step_item();
    // Degenerate box: a single point, done on its first step; then a step after the end.
    start_box(100, 200, 100, 200);
    step_item();
    step_item();
    // Zero x radius: goes straight to region two and walks down a vertical line.
    start_box(500, 40, 500, 44);
    repeat (4) step_item();
    // Zero y radius with corners given right to left.
    start_box(30, 7, 20, 7);
    step_item();
    // Full-range box, both corners reversed; left unfinished.
    start_box(COORD_MAX, COORD_MAX, 0, 0);
    repeat (3) step_item();
    // Full-range box the other way round replaces the one in progress.
    start_box(0, 0, COORD_MAX, COORD_MAX);
    repeat (2) step_item();
    // Odd widths round the radii down; replaces the big ellipse mid-flight.
    start_box(3, 3, 6, 8);
    repeat (5) step_item();
    wait_for_pixels();

    base = sent;
    while (sent - base < STIM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        random_shape();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) step_item();
      end else begin
        start_box($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        repeat ($urandom_range(0, 4)) step_item();
      end
      if ($urandom_range(0, 24) == 0)
        wait_for_pixels();
    end

    // Drain the pixel queue, then give the block time to show any stray transfer.
    wait_for_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
src/mer_pkg.sv
src/mer_if.sv
src/mer_ctrl.sv
src/mer_datapath.sv
src/mer_emit.sv
src/midpoint_ellipse_rasterizer_core.sv
sim/mer_pixel_checker.sv
sim/tb_midpoint_ellipse_rasterizer_core.sv
